### design/iou_pkg.sv
// Shared types and constants for the IoU track label association block.
// Used by the controller, the datapath and the top level.
package iou_pkg;
	localparam int TRACK_DEPTH = 64;
	localparam int FRAME_DETECTIONS = 32;
	localparam int COORD_BITS = 12;
	localparam int TIDX_BITS = $clog2(TRACK_DEPTH);
	localparam int TCNT_BITS = $clog2(TRACK_DEPTH + 1);
	localparam int PIDX_BITS = (FRAME_DETECTIONS > 1) ? $clog2(FRAME_DETECTIONS) : 1;
	localparam int PCNT_BITS = $clog2(FRAME_DETECTIONS + 1);
	localparam int LABEL_BITS = 16;
	localparam int CLASS_BITS = 8;
	localparam int EDGE_BITS = COORD_BITS + 1;
	localparam int AREA_BITS = 2 * COORD_BITS;
	localparam int UNION_BITS = AREA_BITS + 1;
	localparam int CMP_BITS = AREA_BITS + 4;

	localparam logic CMD_DETECT = 1'b0;
	localparam logic CMD_END = 1'b1;

	typedef struct packed {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
	} box_t;

	typedef struct packed {
		logic [CLASS_BITS-1:0] cls;
		logic [LABEL_BITS-1:0] label;
	} tag_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP1,
		ST_CMP2,
		ST_CMP3,
		ST_DEC,
		ST_PUSH,
		ST_ERD,
		ST_EWAIT,
		ST_EOUT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic rd_track;
		logic decide;
		logic push_pending;
		logic rd_pending;
		logic emit;
		logic end_frame;
	} cmd_t;

	typedef struct packed {
		logic is_end;
		logic pend_full;
		logic scan_done;
		logic pend_last;
		logic out_busy;
	} status_t;
endpackage

### design/iou_ctrl.sv
// Controller state machine for the IoU track label association block.
// Depends on iou_pkg; drives the datapath by command and reads its status.
module iou_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  iou_pkg::status_t st,
	output iou_pkg::cmd_t    cmd
);
	import iou_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				if (st.is_end) begin
					state_d = st.pend_last ? ST_IDLE : ST_ERD;
					if (st.pend_last) begin
						cmd.end_frame = 1'b1;
					end else begin
						cmd.rd_pending = 1'b1;
					end
				end else if (st.pend_full) begin
					cmd.push_pending = 1'b1;
					state_d = ST_IDLE;
				end else if (st.scan_done) begin
					state_d = ST_PUSH;
				end else begin
					cmd.rd_track = 1'b1;
					state_d = ST_RD;
				end
			end
			ST_RD: state_d = ST_CMP1;
			ST_CMP1: state_d = ST_CMP2;
			ST_CMP2: state_d = ST_CMP3;
			ST_CMP3: begin
				cmd.decide = 1'b1;
				state_d = ST_DEC;
			end
			ST_PUSH: begin
				cmd.push_pending = 1'b1;
				state_d = ST_IDLE;
			end
			ST_ERD: state_d = ST_EWAIT;
			ST_EWAIT: state_d = ST_EOUT;
			ST_EOUT: begin
				if (!st.out_busy) begin
					cmd.emit = 1'b1;
					if (st.pend_last) begin
						cmd.end_frame = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.rd_pending = 1'b1;
						state_d = ST_ERD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

### design/iou_dp.sv
// Datapath of the IoU track label association block: track table, pending
// store, overlap test, label counter and output register. Depends on iou_pkg.
module iou_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  iou_pkg::cmd_t                cmd,
	output iou_pkg::status_t             st,
	input  logic                         first_label_we,
	input  logic [iou_pkg::LABEL_BITS-1:0] first_label,
	input  logic                         command,
	input  logic [iou_pkg::COORD_BITS-1:0] box_left,
	input  logic [iou_pkg::COORD_BITS-1:0] box_top,
	input  logic [iou_pkg::COORD_BITS-1:0] box_width,
	input  logic [iou_pkg::COORD_BITS-1:0] box_height,
	input  logic [iou_pkg::CLASS_BITS-1:0] det_class,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [iou_pkg::LABEL_BITS-1:0] track_label,
	output logic [iou_pkg::CLASS_BITS-1:0] out_class,
	output logic                         dropped,
	output logic                         last
);
	import iou_pkg::*;

	box_t track_box_mem [TRACK_DEPTH];
	tag_t track_tag_mem [TRACK_DEPTH];
	box_t pend_box_mem [FRAME_DETECTIONS];
	tag_t pend_tag_mem [FRAME_DETECTIONS];

	logic is_end_q;
	box_t det_q;
	logic [CLASS_BITS-1:0] det_cls_q;
	logic [LABEL_BITS-1:0] det_label_q;
	logic [TCNT_BITS-1:0] track_count_q, rd_ptr_q, wr_ptr_q;
	logic [PCNT_BITS-1:0] pend_count_q, pend_ptr_q;
	logic [LABEL_BITS-1:0] next_label_q;
	logic overflow_q;

	box_t rbox_q;
	tag_t rtag_q;
	tag_t ptag_q;
	logic [TCNT_BITS-1:0] ecount_q;

	logic [EDGE_BITS-1:0] ax2, bx2, ay2, by2, x1, y1, x2, y2;
	logic [COORD_BITS-1:0] iw_s1, ih_s1;
	logic ovl_s1, cls_s1;
	logic [AREA_BITS-1:0] inter_s2, aa_s2, ba_s2;
	logic ovl_s2, cls_s2;
	logic match_q;

	logic [LABEL_BITS-1:0] lab_inc;
	logic [LABEL_BITS-1:0] new_label;
	logic [UNION_BITS-1:0] uni;

	assign st.is_end = is_end_q;
	assign st.pend_full = (pend_count_q == PCNT_BITS'(FRAME_DETECTIONS));
	assign st.scan_done = (rd_ptr_q == ecount_q);
	assign st.pend_last = (pend_ptr_q == pend_count_q);
	assign st.out_busy = out_valid && !out_ready;

	assign ax2 = EDGE_BITS'(det_q.left) + EDGE_BITS'(det_q.width);
	assign ay2 = EDGE_BITS'(det_q.top) + EDGE_BITS'(det_q.height);
	assign bx2 = EDGE_BITS'(rbox_q.left) + EDGE_BITS'(rbox_q.width);
	assign by2 = EDGE_BITS'(rbox_q.top) + EDGE_BITS'(rbox_q.height);
	assign x1 = (det_q.left > rbox_q.left) ? EDGE_BITS'(det_q.left) : EDGE_BITS'(rbox_q.left);
	assign y1 = (det_q.top > rbox_q.top) ? EDGE_BITS'(det_q.top) : EDGE_BITS'(rbox_q.top);
	assign x2 = (ax2 < bx2) ? ax2 : bx2;
	assign y2 = (ay2 < by2) ? ay2 : by2;
	assign uni = UNION_BITS'(aa_s2) + UNION_BITS'(ba_s2) - UNION_BITS'(inter_s2);
	assign lab_inc = next_label_q + LABEL_BITS'(1);
	assign new_label = (lab_inc == '0) ? LABEL_BITS'(1) : lab_inc;

	always_ff @(posedge clk) begin
		iw_s1 <= COORD_BITS'(x2 - x1);
		ih_s1 <= COORD_BITS'(y2 - y1);
		ovl_s1 <= (x2 > x1) && (y2 > y1);
		cls_s1 <= (rtag_q.cls == det_cls_q);
		inter_s2 <= iw_s1 * ih_s1;
		aa_s2 <= det_q.width * det_q.height;
		ba_s2 <= rbox_q.width * rbox_q.height;
		ovl_s2 <= ovl_s1;
		cls_s2 <= cls_s1;
		match_q <= ovl_s2 && cls_s2 &&
			(CMP_BITS'(inter_s2) * CMP_BITS'(10) >= CMP_BITS'(uni));
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			det_q <= '{box_left, box_top, box_width, box_height};
			det_cls_q <= det_class;
		end
		if (cmd.rd_track) begin
			rbox_q <= track_box_mem[rd_ptr_q[TIDX_BITS-1:0]];
			rtag_q <= track_tag_mem[rd_ptr_q[TIDX_BITS-1:0]];
		end
		if (cmd.decide && !match_q) begin
			track_box_mem[wr_ptr_q[TIDX_BITS-1:0]] <= rbox_q;
			track_tag_mem[wr_ptr_q[TIDX_BITS-1:0]] <= rtag_q;
		end
		if (cmd.push_pending && !st.pend_full) begin
			pend_box_mem[pend_count_q[PIDX_BITS-1:0]] <= det_q;
			pend_tag_mem[pend_count_q[PIDX_BITS-1:0]] <= '{det_cls_q, det_label_q};
		end
		if (cmd.rd_pending) begin
			ptag_q <= pend_tag_mem[pend_ptr_q[PIDX_BITS-1:0]];
			rbox_q <= pend_box_mem[pend_ptr_q[PIDX_BITS-1:0]];
		end
		if (cmd.emit && ecount_q < TCNT_BITS'(TRACK_DEPTH)) begin
			track_box_mem[ecount_q[TIDX_BITS-1:0]] <= rbox_q;
			track_tag_mem[ecount_q[TIDX_BITS-1:0]] <=
				'{ptag_q.cls, (ptag_q.label == '0) ? next_label_q : ptag_q.label};
		end
		if (cmd.emit) begin
			track_label <= (ptag_q.label == '0) ? next_label_q : ptag_q.label;
			out_class <= ptag_q.cls;
			dropped <= overflow_q || (ecount_q >= TCNT_BITS'(TRACK_DEPTH));
			last <= st.pend_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_end_q <= 1'b0;
			det_label_q <= '0;
			track_count_q <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			pend_count_q <= '0;
			pend_ptr_q <= '0;
			next_label_q <= LABEL_BITS'(1);
			overflow_q <= 1'b0;
			ecount_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (first_label_we) begin
				next_label_q <= (first_label == '0) ? LABEL_BITS'(1) : first_label;
			end
			if (cmd.load_in) begin
				is_end_q <= (command == CMD_END);
				det_label_q <= '0;
				rd_ptr_q <= '0;
				wr_ptr_q <= '0;
				pend_ptr_q <= '0;
				ecount_q <= track_count_q;
			end
			if (cmd.rd_track) begin
				rd_ptr_q <= rd_ptr_q + TCNT_BITS'(1);
			end
			if (cmd.decide) begin
				if (match_q) begin
					det_label_q <= rtag_q.label;
					track_count_q <= track_count_q - TCNT_BITS'(1);
				end else begin
					wr_ptr_q <= wr_ptr_q + TCNT_BITS'(1);
				end
			end
			if (cmd.decide && match_q) begin
				rd_ptr_q <= rd_ptr_q;
			end
			if (cmd.push_pending) begin
				if (st.pend_full) begin
					overflow_q <= 1'b1;
				end else begin
					pend_count_q <= pend_count_q + PCNT_BITS'(1);
				end
			end
			if (cmd.rd_pending) begin
				pend_ptr_q <= pend_ptr_q + PCNT_BITS'(1);
			end
			if (cmd.emit) begin
				if (ptag_q.label == '0) begin
					next_label_q <= new_label;
				end
				if (ecount_q < TCNT_BITS'(TRACK_DEPTH)) begin
					ecount_q <= ecount_q + TCNT_BITS'(1);
				end
			end
			if (cmd.end_frame) begin
				track_count_q <= ecount_q + TCNT_BITS'(cmd.emit && ecount_q < TCNT_BITS'(TRACK_DEPTH));
				pend_count_q <= '0;
				overflow_q <= 1'b0;
			end
		end
	end
endmodule

### design/iou_track_label_association.sv
// Top level of the IoU track label association block.
// Depends on iou_pkg, iou_ctrl and iou_dp.
// A detection beat reads each of the N tracks held (up to 64) in turn and tests
// it through a three-stage overlap pipeline on a single table port. An
// end-of-frame beat emits each pending detection through one output register
// and appends it to the table while the table has room; an output stall holds
// the emission. The input is taken only between items.
module iou_track_label_association (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [iou_pkg::LABEL_BITS-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            command,
	input  logic [iou_pkg::COORD_BITS-1:0]  box_left,
	input  logic [iou_pkg::COORD_BITS-1:0]  box_top,
	input  logic [iou_pkg::COORD_BITS-1:0]  box_width,
	input  logic [iou_pkg::COORD_BITS-1:0]  box_height,
	input  logic [iou_pkg::CLASS_BITS-1:0]  det_class,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [iou_pkg::LABEL_BITS-1:0]  track_label,
	output logic [iou_pkg::CLASS_BITS-1:0]  out_class,
	output logic                            dropped,
	output logic                            last
);
	import iou_pkg::*;

	cmd_t cmd;
	status_t st;

	iou_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.st(st), .cmd(cmd)
	);

	iou_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.first_label_we(cfg_we), .first_label(cfg_wdata),
		.command(command), .box_left(box_left), .box_top(box_top),
		.box_width(box_width), .box_height(box_height), .det_class(det_class),
		.out_valid(out_valid), .out_ready(out_ready), .track_label(track_label),
		.out_class(out_class), .dropped(dropped), .last(last)
	);
endmodule

### design/iou_checker.sv
// Port-level checks for the IoU track label association block.
// Bound to iou_track_label_association; depends on its ports only.
module iou_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] track_label,
	input logic        last
);
	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> track_label != 16'd0) else $error("zero label");
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && !last) |-> !in_ready) else $error("input taken mid-frame");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(track_label))
		else $error("result changed while stalled");
endmodule

bind iou_track_label_association iou_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .track_label(track_label),
	.last(last)
);
